@@ sv/cnlic_pkg.sv @@
// shared types and constants for the card number luhn and issuer check
`default_nettype none

package cnlic_pkg;

   localparam int unsigned MAX_DIGITS  = 19;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [3:0] digit;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       luhn_ok;
      logic [3:0] issuer;
      logic [4:0] digit_count;
      logic [6:0] plain_sum;
      logic [6:0] doubled_sum;
      logic [7:0] total_sum;
      logic       too_long;
   } rsp_type;

   // one finished number handed from the front to the back
   typedef struct packed {
      logic [4:0]  count;
      logic [3:0]  pre1;
      logic [6:0]  pre2;
      logic [9:0]  pre3;
      logic [13:0] pre4;
      logic [19:0] pre6;
      logic [6:0]  plain;
      logic [6:0]  dbl;
      logic        too_long;
   } summary_type;

endpackage

`default_nettype wire

@@ sv/cnlic_front.sv @@
// front: accepts digit beats, keeps luhn sums, count and prefix per number
`default_nettype none

module cnlic_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cnlic_pkg::req_type     req_beat,
   input  wire logic                   q_full,
   output logic                        q_push,
   output cnlic_pkg::summary_type      q_data
);

   logic [6:0]  plain_even_ff, plain_even_in;
   logic [6:0]  plain_odd_ff,  plain_odd_in;
   logic [6:0]  dbl_even_ff,   dbl_even_in;
   logic [6:0]  dbl_odd_ff,    dbl_odd_in;
   logic [4:0]  count_ff,      count_in;
   logic [3:0]  pre1_ff,       pre1_in;
   logic [6:0]  pre2_ff,       pre2_in;
   logic [9:0]  pre3_ff,       pre3_in;
   logic [13:0] pre4_ff,       pre4_in;
   logic [19:0] pre6_ff,       pre6_in;
   logic        ovf_ff,        ovf_in;

   logic [3:0] d;
   logic [4:0] twice;
   logic [3:0] ds;
   logic       sig;
   logic       take;
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      d     = (req_beat.digit > 4'd9) ? 4'd9 : req_beat.digit;
      twice = {d, 1'b0};
      ds    = (twice >= 5'd10) ? 4'(twice - 5'd9) : twice[3:0];
      sig   = (d != 4'd0) || (count_ff != 5'd0);
      take  = sig && (count_ff < 5'(cnlic_pkg::MAX_DIGITS));

      plain_even_in = plain_even_ff;
      plain_odd_in  = plain_odd_ff;
      dbl_even_in   = dbl_even_ff;
      dbl_odd_in    = dbl_odd_ff;
      count_in      = count_ff;
      pre1_in       = pre1_ff;
      pre2_in       = pre2_ff;
      pre3_in       = pre3_ff;
      pre4_in       = pre4_ff;
      pre6_in       = pre6_ff;
      ovf_in        = ovf_ff || (sig && !take);

      if (take) begin
         if (!count_ff[0]) begin
            plain_even_in = plain_even_ff + 7'(d);
            dbl_even_in   = dbl_even_ff + 7'(ds);
         end else begin
            plain_odd_in = plain_odd_ff + 7'(d);
            dbl_odd_in   = dbl_odd_ff + 7'(ds);
         end
         if (count_ff < 5'd1) pre1_in = d;
         if (count_ff < 5'd2) pre2_in = (pre2_ff << 3) + (pre2_ff << 1) + 7'(d);
         if (count_ff < 5'd3) pre3_in = (pre3_ff << 3) + (pre3_ff << 1) + 10'(d);
         if (count_ff < 5'd4) pre4_in = (pre4_ff << 3) + (pre4_ff << 1) + 14'(d);
         if (count_ff < 5'd6) pre6_in = (pre6_ff << 3) + (pre6_ff << 1) + 20'(d);
         count_in = count_ff + 5'd1;
      end
   end

   always_comb begin
      q_push           = accept && req_beat.last;
      q_data.count     = count_in;
      q_data.pre1      = pre1_in;
      q_data.pre2      = pre2_in;
      q_data.pre3      = pre3_in;
      q_data.pre4      = pre4_in;
      q_data.pre6      = pre6_in;
      q_data.too_long  = ovf_in;
      // last digit at an even index from the left takes the even plain sum
      if (count_in[0]) begin
         q_data.plain = plain_even_in;
         q_data.dbl   = dbl_odd_in;
      end else begin
         q_data.plain = plain_odd_in;
         q_data.dbl   = dbl_even_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_beat.last)) begin
         plain_even_ff <= '0;
         plain_odd_ff  <= '0;
         dbl_even_ff   <= '0;
         dbl_odd_ff    <= '0;
         count_ff      <= '0;
         pre1_ff       <= '0;
         pre2_ff       <= '0;
         pre3_ff       <= '0;
         pre4_ff       <= '0;
         pre6_ff       <= '0;
         ovf_ff        <= 1'b0;
      end else if (accept) begin
         plain_even_ff <= plain_even_in;
         plain_odd_ff  <= plain_odd_in;
         dbl_even_ff   <= dbl_even_in;
         dbl_odd_ff    <= dbl_odd_in;
         count_ff      <= count_in;
         pre1_ff       <= pre1_in;
         pre2_ff       <= pre2_in;
         pre3_ff       <= pre3_in;
         pre4_ff       <= pre4_in;
         pre6_ff       <= pre6_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/cnlic_queue.sv @@
// short queue of finished number summaries between front and back
`default_nettype none

module cnlic_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire cnlic_pkg::summary_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output cnlic_pkg::summary_type      pop_data
);

   localparam int unsigned DEPTH = cnlic_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = cnlic_pkg::QPTR_W;
   localparam int unsigned CW    = cnlic_pkg::QCNT_W;

   cnlic_pkg::summary_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff,    cnt_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/cnlic_back.sv @@
// back: luhn verdict, issuer class and result register
`default_nettype none

module cnlic_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  wire cnlic_pkg::summary_type q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output cnlic_pkg::rsp_type          rsp_beat
);

   function automatic logic in_open20(input logic [19:0] v, input logic [19:0] lo,
                                      input logic [19:0] hi);
      in_open20 = (v > lo) && (v < hi);
   endfunction

   function automatic logic [3:0] classify(input cnlic_pkg::summary_type s);
      logic [4:0] n;
      logic       l16_19;
      logic       l12_19;
      logic [3:0] cls;
      n      = s.count;
      l16_19 = (n > 5'd15) && (n < 5'd20);
      l12_19 = (n > 5'd11) && (n < 5'd20);
      cls    = 4'd0;
      if (n < 5'd6) begin
         cls = 4'd0;
      end else if (s.pre1 == 4'd4 && (n == 5'd13 || n == 5'd16)) begin
         cls = 4'd1;
      end else if ((s.pre2 == 7'd34 || s.pre2 == 7'd37) && n == 5'd15) begin
         cls = 4'd2;
      end else if ((s.pre2 == 7'd60 || s.pre4 == 14'd6521 || s.pre4 == 14'd6522)
                   && n == 5'd16) begin
         cls = 4'd3;
      end else if (s.pre2 > 7'd50 && s.pre2 < 7'd56 && n == 5'd16) begin
         cls = 4'd4;
      end else if (s.pre2 == 7'd31 && n == 5'd19) begin
         cls = 4'd5;
      end else if (s.pre2 == 7'd62 && l16_19) begin
         cls = 4'd6;
      end else if (s.pre2 == 7'd36 && n > 5'd13 && n < 5'd20) begin
         cls = 4'd7;
      end else if ((s.pre2 == 7'd38 || s.pre2 == 7'd39 || s.pre4 == 14'd3095 ||
                    (s.pre3 > 10'd299 && s.pre3 < 10'd306)) && l16_19) begin
         cls = 4'd7;
      end else if ((s.pre2 == 7'd64 || s.pre2 == 7'd65 || s.pre4 == 14'd6011 ||
                    in_open20(s.pre6, 20'd622125, 20'd622926) ||
                    in_open20(s.pre6, 20'd623999, 20'd627000) ||
                    in_open20(s.pre6, 20'd628199, 20'd628900)) && l16_19) begin
         cls = 4'd8;
      end else if (s.pre3 == 10'd636 && l16_19) begin
         cls = 4'd9;
      end else if (s.pre3 > 10'd636 && s.pre3 < 10'd640 && n == 5'd16) begin
         cls = 4'd10;
      end else if ((s.pre4 == 14'd5610 || in_open20(s.pre6, 20'd560220, 20'd560226))
                   && n == 5'd16) begin
         cls = 4'd11;
      end else if ((s.pre4 == 14'd6759 || s.pre6 == 20'd676770 || s.pre6 == 20'd676774)
                   && l12_19) begin
         cls = 4'd12;
      end else if ((s.pre2 == 7'd50 || (s.pre2 > 7'd55 && s.pre2 < 7'd70)) && l12_19) begin
         cls = 4'd13;
      end else if (in_open20(s.pre6, 20'd979199, 20'd979290) && n == 5'd16) begin
         cls = 4'd14;
      end else if (s.pre4 > 14'd3527 && s.pre4 < 14'd3590 && l16_19) begin
         cls = 4'd15;
      end
      classify = cls;
   endfunction

   logic               rsp_valid_ff, rsp_valid_in;
   cnlic_pkg::rsp_type rsp_ff,       rsp_in;
   logic [7:0]         total;
   logic [15:0]        prod;
   logic [4:0]         quot;
   logic [7:0]         rem;
   logic               ok;

   assign q_pop     = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   always_comb begin
      total = 8'(q_data.plain) + 8'(q_data.dbl);
      // divide by ten via reciprocal, exact for this range
      prod  = 16'(total) * 16'd205;
      quot  = prod[15:11];
      rem   = total - 8'(({3'b000, quot} << 3) + ({3'b000, quot} << 1));
      ok    = (rem == 8'd0) && (q_data.count != 5'd0) && !q_data.too_long;

      rsp_in.luhn_ok     = ok;
      rsp_in.issuer      = ok ? classify(q_data) : 4'd0;
      rsp_in.digit_count = q_data.count;
      rsp_in.plain_sum   = q_data.plain;
      rsp_in.doubled_sum = q_data.dbl;
      rsp_in.total_sum   = total;
      rsp_in.too_long    = q_data.too_long;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/card_number_luhn_issuer_check.sv @@
// top level of the card number luhn and issuer check
//
// req channel: one decimal digit per beat, most significant first, last set
// on the final digit of a number. leading zero digits are skipped, digits
// above nine count as nine; one digit is taken each cycle the queue is not full.
// rsp channel: one beat per number, issued for the digit beat with last set:
// luhn verdict, issuer class, digit count, the two partial sums, their total
// and the too-long flag.
// the summary queue is written at the edge that takes the last digit, the
// output register when the back pops that entry, which waits while a held
// response is not taken. the front adds no register stage on this path.
// throughput: one digit and one response per cycle while neither side stalls.
// the summary queue holds two finished numbers; while it is full, req_ready
// is low. a stalled rsp_ready holds the response register and fills the
// queue, digits keep flowing until it is full.
// reset clears all sums, counts, the queue and the response valid.
`default_nettype none

module card_number_luhn_issuer_check (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cnlic_pkg::req_type  req_beat,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output cnlic_pkg::rsp_type       rsp_beat
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   cnlic_pkg::summary_type q_push_data;
   cnlic_pkg::summary_type q_pop_data;

   cnlic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   cnlic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   cnlic_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat)
   );

endmodule

`default_nettype wire

@@ bench/card_check_monitor.sv @@
// watches both channels, predicts each card verdict and compares the response beats
`timescale 1ns / 1ps

module card_check_monitor (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  cnlic_pkg::req_type  req_beat,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  cnlic_pkg::rsp_type  rsp_beat,
   output int                  outstanding,
   output int                  fail_count
);

   typedef enum logic [3:0] {
      CLASS_NONE       = 4'd0,
      CLASS_P4         = 4'd1,
      CLASS_P34_37     = 4'd2,
      CLASS_P60_652X   = 4'd3,
      CLASS_P51_55     = 4'd4,
      CLASS_P31        = 4'd5,
      CLASS_P62        = 4'd6,
      CLASS_P36_3X     = 4'd7,
      CLASS_P64_65_62X = 4'd8,
      CLASS_P636       = 4'd9,
      CLASS_P637_639   = 4'd10,
      CLASS_P5610      = 4'd11,
      CLASS_P6759      = 4'd12,
      CLASS_P50_5X_6X  = 4'd13,
      CLASS_P9792      = 4'd14,
      CLASS_P3528_3589 = 4'd15
   } issuer_class_type;

   logic [6:0]  plain_at_even;
   logic [6:0]  plain_at_odd;
   logic [6:0]  doubled_at_even;
   logic [6:0]  doubled_at_odd;
   logic [4:0]  sig_count;
   logic [19:0] head_value;
   logic        overflow_seen;
   int          mismatches = 0;

   cnlic_pkg::rsp_type expected_verdicts [$];

   assign fail_count = mismatches;

   function automatic bit between(input int unsigned v, input int unsigned lo,
                                  input int unsigned hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic issuer_class_type issuer_class(input int unsigned n,
                                                     input int unsigned p6);
      int unsigned p1, p2, p3, p4;
      bit          l16_19, l12_19;
      p1 = p6 / 100000;
      p2 = p6 / 10000;
      p3 = p6 / 1000;
      p4 = p6 / 100;
      l16_19 = between(n, 16, 19);
      l12_19 = between(n, 12, 19);
      if (n < 6) return CLASS_NONE;
      if (p1 == 4 && (n == 13 || n == 16)) return CLASS_P4;
      if ((p2 == 34 || p2 == 37) && n == 15) return CLASS_P34_37;
      if ((p2 == 60 || p4 == 6521 || p4 == 6522) && n == 16) return CLASS_P60_652X;
      if (between(p2, 51, 55) && n == 16) return CLASS_P51_55;
      if (p2 == 31 && n == 19) return CLASS_P31;
      if (p2 == 62 && l16_19) return CLASS_P62;
      if (p2 == 36 && between(n, 14, 19)) return CLASS_P36_3X;
      if ((p2 == 38 || p2 == 39 || p4 == 3095 || between(p3, 300, 305)) && l16_19)
         return CLASS_P36_3X;
      if ((p2 == 64 || p2 == 65 || p4 == 6011 || between(p6, 622126, 622925) ||
           between(p6, 624000, 626999) || between(p6, 628200, 628899)) && l16_19)
         return CLASS_P64_65_62X;
      if (p3 == 636 && l16_19) return CLASS_P636;
      if (between(p3, 637, 639) && n == 16) return CLASS_P637_639;
      if ((p4 == 5610 || between(p6, 560221, 560225)) && n == 16) return CLASS_P5610;
      if ((p4 == 6759 || p6 == 676770 || p6 == 676774) && l12_19) return CLASS_P6759;
      if ((p2 == 50 || between(p2, 56, 69)) && l12_19) return CLASS_P50_5X_6X;
      if (between(p6, 979200, 979289) && n == 16) return CLASS_P9792;
      if (between(p4, 3528, 3589) && l16_19) return CLASS_P3528_3589;
      return CLASS_NONE;
   endfunction

   task automatic clear_card;
      plain_at_even   = '0;
      plain_at_odd    = '0;
      doubled_at_even = '0;
      doubled_at_odd  = '0;
      sig_count       = '0;
      head_value      = '0;
      overflow_seen   = 1'b0;
   endtask

   task automatic absorb_digit(input cnlic_pkg::req_type b);
      int unsigned        d, twice, dsum, plain, dbl, total;
      bit                 ok;
      cnlic_pkg::rsp_type verdict;
      d = (b.digit > 4'd9) ? 9 : b.digit;
      if (d != 0 || sig_count != 0) begin
         if (sig_count >= cnlic_pkg::MAX_DIGITS) begin
            overflow_seen = 1'b1;
         end else begin
            twice = d * 2;
            dsum  = (twice % 10) + (twice / 10);
            if (!sig_count[0]) begin
               plain_at_even   = 7'(plain_at_even + d);
               doubled_at_even = 7'(doubled_at_even + dsum);
            end else begin
               plain_at_odd   = 7'(plain_at_odd + d);
               doubled_at_odd = 7'(doubled_at_odd + dsum);
            end
            if (sig_count < 6) head_value = 20'(head_value * 10 + d);
            sig_count = sig_count + 5'd1;
         end
      end
      if (b.last) begin
         if (sig_count == 0) begin
            plain = 0;
            dbl   = 0;
         end else if (sig_count[0]) begin
            plain = plain_at_even;
            dbl   = doubled_at_odd;
         end else begin
            plain = plain_at_odd;
            dbl   = doubled_at_even;
         end
         total = plain + dbl;
         ok = (total % 10 == 0) && (sig_count != 0) && !overflow_seen;
         verdict.luhn_ok     = ok;
         verdict.issuer      = ok ? issuer_class(sig_count, head_value) : CLASS_NONE;
         verdict.digit_count = sig_count;
         verdict.plain_sum   = plain[6:0];
         verdict.doubled_sum = dbl[6:0];
         verdict.total_sum   = total[7:0];
         verdict.too_long    = overflow_seen;
         expected_verdicts.push_back(verdict);
         clear_card();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cnlic_pkg::rsp_type want;
      if (reset) begin
         clear_card();
         expected_verdicts.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: extra beat, expected none, actual ok %0d issuer %0d count %0d",
                        $time, rsp_beat.luhn_ok, rsp_beat.issuer, rsp_beat.digit_count);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("luhn_ok", want.luhn_ok, rsp_beat.luhn_ok);
               check_field("issuer", want.issuer, rsp_beat.issuer);
               check_field("digit_count", want.digit_count, rsp_beat.digit_count);
               check_field("plain_sum", want.plain_sum, rsp_beat.plain_sum);
               check_field("doubled_sum", want.doubled_sum, rsp_beat.doubled_sum);
               check_field("total_sum", want.total_sum, rsp_beat.total_sum);
               check_field("too_long", want.too_long, rsp_beat.too_long);
            end
         end
         if (req_valid && req_ready) absorb_digit(req_beat);
         outstanding <= expected_verdicts.size();
      end
   end

endmodule

@@ bench/tb_card_number_luhn_issuer_check.sv @@
// top of the card number check bench: clock, reset, digit stream and verdict
`timescale 1ns / 1ps

module tb_card_number_luhn_issuer_check;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cnlic_pkg::req_type req_beat  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   cnlic_pkg::rsp_type rsp_beat;
   int                 outstanding;
   int                 fail_count;

   int  send_gap_pct = 0;
   int  stall_pct    = 0;
   bit  quiet        = 1'b0;
   int  digits_sent  = 0;
   int  cards_sent   = 0;

   logic [3:0] card_buf [0:31];
   int         card_len;

   int unsigned prefix_pool [0:53] = '{
      4, 34, 37, 60, 6521, 6522, 51, 55, 31, 62, 36, 38, 39, 3095, 300, 305,
      64, 65, 6011, 622126, 622925, 624000, 626999, 628200, 628899, 636, 637, 639,
      5610, 560221, 560225, 6759, 676770, 676774, 50, 56, 69, 979200, 979289,
      3528, 3589, 622125, 622926, 979199, 979290, 3527, 3590, 676773, 560226,
      299, 306, 35, 8, 1
   };

   card_number_luhn_issuer_check dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   card_check_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // response side stalls in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_digit(input logic [3:0] d, input logic l, input bit hold_after);
      cnlic_pkg::req_type b;
      int                 gap;
      b.digit = d;
      b.last  = l;
      req_valid <= 1'b1;
      req_beat  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      digits_sent++;
      if (hold_after) begin
         req_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_card(input bit hold_after);
      int i;
      for (i = 0; i < card_len; i++)
         send_digit(card_buf[i], i == card_len - 1, hold_after && (i == card_len - 1));
      cards_sent++;
   endtask

   task automatic wait_drained;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // prefix from the pool, random body, luhn check digit most of the time
   task automatic build_card;
      int unsigned v, tmp, dv, acc;
      int          plen, n, i, zeros;
      v = prefix_pool[$urandom_range(0, 53)];
      plen = 0;
      tmp = v;
      while (tmp > 0) begin
         tmp = tmp / 10;
         plen++;
      end
      zeros = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 23);
      else if ($urandom_range(0, 3) == 0) n = 16;
      else n = $urandom_range(12, 19);
      if (n <= plen) n = plen + 1;
      for (i = 0; i < zeros; i++) card_buf[i] = 4'd0;
      tmp = v;
      for (i = plen - 1; i >= 0; i--) begin
         card_buf[zeros + i] = 4'(tmp % 10);
         tmp = tmp / 10;
      end
      for (i = plen; i < n - 1; i++) card_buf[zeros + i] = 4'($urandom_range(0, 9));
      acc = 0;
      for (i = 0; i < n - 1; i++) begin
         dv = card_buf[zeros + i];
         if ((n - i) % 2 == 0) begin
            dv = dv * 2;
            if (dv > 9) dv = dv - 9;
         end
         acc = acc + dv;
      end
      card_buf[zeros + n - 1] = 4'((10 - acc % 10) % 10);
      if ($urandom_range(0, 9) == 0) card_buf[zeros + n - 1] = 4'($urandom_range(0, 9));
      // digits above nine behave as nine, so swapping them in keeps the checksum
      for (i = zeros; i < zeros + n; i++)
         if (card_buf[i] == 4'd9 && $urandom_range(0, 7) == 0)
            card_buf[i] = 4'($urandom_range(10, 15));
      card_len = zeros + n;
   endtask

   task automatic build_noise;
      int i;
      bit all_zero;
      card_len = $urandom_range(1, 23);
      all_zero = ($urandom_range(0, 9) == 0);
      for (i = 0; i < card_len; i++) begin
         if (all_zero) card_buf[i] = 4'd0;
         else if ($urandom_range(0, 7) == 0) card_buf[i] = 4'($urandom_range(10, 15));
         else card_buf[i] = 4'($urandom_range(0, 9));
      end
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all-zero numbers, single digits, a clamped digit, skipped zeros, a valid card
      send_digit(4'd0, 1'b1, 1'b0);
      send_digit(4'd0, 1'b0, 1'b0);
      send_digit(4'd0, 1'b1, 1'b0);
      send_digit(4'd9, 1'b1, 1'b0);
      send_digit(4'd15, 1'b1, 1'b0);
      send_digit(4'd0, 1'b0, 1'b0);
      send_digit(4'd0, 1'b0, 1'b0);
      send_digit(4'd5, 1'b0, 1'b0);
      send_digit(4'd9, 1'b1, 1'b0);
      send_digit(4'd4, 1'b0, 1'b0);
      for (i = 0; i < 14; i++) send_digit(4'd1, 1'b0, 1'b0);
      send_digit(4'd1, 1'b1, 1'b0);

      while (digits_sent < 950) begin
         if (cards_sent % 6 == 0) begin
            case ($urandom_range(0, 2))
               0: send_gap_pct = 0;
               1: send_gap_pct = 15;
               default: send_gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 50;
            endcase
         end
         if (digits_sent > 850) quiet = 1'b1;
         if ($urandom_range(0, 4) == 0) build_noise();
         else build_card();
         if (cards_sent == 20 || cards_sent == 45) begin
            send_card(1'b1);
            wait_drained();
         end else begin
            send_card(1'b0);
         end
      end

      build_card();
      send_card(1'b1);
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/cnlic_pkg.sv
sv/cnlic_front.sv
sv/cnlic_queue.sv
sv/cnlic_back.sv
sv/card_number_luhn_issuer_check.sv
bench/card_check_monitor.sv
bench/tb_card_number_luhn_issuer_check.sv
